// ===== rtl/obl_pkg.sv =====
`timescale 1ns / 1ps

package obl_pkg;

   // Table sizes.
   localparam int ORDER_SLOTS = 4096;
   localparam int LEVEL_SLOTS = 256;
   localparam int TOP_LEVELS  = 10;

   // Derived widths.
   localparam int OIDX_W = $clog2(ORDER_SLOTS);
   localparam int OCNT_W = $clog2(ORDER_SLOTS + 1);
   localparam int LIDX_W = $clog2(LEVEL_SLOTS);
   localparam int LCNT_W = $clog2(LEVEL_SLOTS + 1);
   localparam int LADR_W = LIDX_W + 1;
   localparam int RANK_W = $clog2(TOP_LEVELS + 1);
   localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);

   localparam int ID_W    = 64;
   localparam int PRICE_W = 64;
   localparam int QTY_W   = 32;
   localparam int TOTAL_W = 48;

   localparam logic [PRICE_W-1:0] PRICE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Event actions.
   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_CANCEL = 3'd1;
   localparam logic [2:0] ACT_MODIFY = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;

   // Sides.
   localparam logic [1:0] SIDE_BID = 2'd0;
   localparam logic [1:0] SIDE_ASK = 2'd1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   size;
      logic               ask;
      logic               valid;
   } slot_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TOTAL_W-1:0] total;
      logic [CNT_W-1:0]   count;
   } level_type;

endpackage

// ===== rtl/obl_ram.sv =====
`timescale 1ns / 1ps

module obl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/order_book_level_builder_top.sv =====
`timescale 1ns / 1ps

// Market-by-order book builder. Each accepted item is one event (add, cancel,
// modify, clear or no-op); after the event the block returns TOP_LEVELS ask
// level items, best price first, then TOP_LEVELS bid level items, the last
// bid item flagged with last. One event is handled at a time. The order
// table lives in one memory and is searched one slot a cycle, so an add,
// cancel or modify walks the whole table unless the search stops early at a
// slot whose ID matches. Each level search then reads the sorted levels one
// at a time, and inserting or removing a level moves the levels behind it
// one by one, a read and then a write, in the sorted level memory. Each
// result item is read from the level memory, registered and held until the
// consumer takes it. After reset, and on every clear event, a clearing pass
// invalidates the order table; no item is accepted during the pass after
// reset.

module order_book_level_builder_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_action,
   input  logic [63:0]                  req_order_id,
   input  logic [1:0]                   req_side,
   input  logic signed [63:0]           req_price,
   input  logic [31:0]                  req_quantity,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_level_side,
   output logic [3:0]                   rsp_level_rank,
   output logic                         rsp_present,
   output logic signed [63:0]           rsp_level_price,
   output logic [47:0]                  rsp_level_total,
   output logic                         rsp_overflow,
   output logic                         rsp_last
);

   import obl_pkg::*;

   // Sequencer states.
   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_SCAN      = 5'd2;
   localparam logic [4:0] S_SCAN_END  = 5'd3;
   localparam logic [4:0] S_FIND_RD   = 5'd4;
   localparam logic [4:0] S_FIND_CHK  = 5'd5;
   localparam logic [4:0] S_DECIDE    = 5'd6;
   localparam logic [4:0] S_LADD      = 5'd7;
   localparam logic [4:0] S_SHUP_RD   = 5'd8;
   localparam logic [4:0] S_SHUP_WR   = 5'd9;
   localparam logic [4:0] S_LREM      = 5'd10;
   localparam logic [4:0] S_SHDN_RD   = 5'd11;
   localparam logic [4:0] S_SHDN_WR   = 5'd12;
   localparam logic [4:0] S_ADD_END   = 5'd13;
   localparam logic [4:0] S_REM_END   = 5'd14;
   localparam logic [4:0] S_EMIT_RD   = 5'd15;
   localparam logic [4:0] S_EMIT_CAP  = 5'd16;
   localparam logic [4:0] S_EMIT_WAIT = 5'd17;

   // What a finished level search is for.
   localparam logic [1:0] PH_ADDNEW = 2'd0;
   localparam logic [1:0] PH_OLD    = 2'd1;
   localparam logic [1:0] PH_CHK    = 2'd2;
   localparam logic [1:0] PH_ADD    = 2'd3;

   function automatic logic [LADR_W-1:0] lvl_addr(input logic side,
                                                 input logic [LCNT_W-1:0] idx);
      lvl_addr = {side, idx[LIDX_W-1:0]};
   endfunction

   logic [4:0]          state_ff, state_in;
   logic [2:0]          act_ff, act_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic                side_ff, side_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [QTY_W-1:0]    qty_ff, qty_in;
   logic [1:0]          phase_ff, phase_in;
   logic [OCNT_W-1:0]   sa_ff, sa_in;
   logic                srv_ff, srv_in;
   logic [OIDX_W-1:0]   sraddr_ff, sraddr_in;
   logic                m_hit_ff, m_hit_in;
   logic [OIDX_W-1:0]   m_idx_ff, m_idx_in;
   slot_type            m_slot_ff, m_slot_in;
   logic                fr_hit_ff, fr_hit_in;
   logic [OIDX_W-1:0]   fr_idx_ff, fr_idx_in;
   logic [PRICE_W-1:0]  fp_ff, fp_in;
   logic [LCNT_W-1:0]   fi_ff, fi_in;
   logic                f_hit_ff, f_hit_in;
   logic [LCNT_W-1:0]   f_idx_ff, f_idx_in;
   level_type           f_lvl_ff, f_lvl_in;
   logic                o_hit_ff, o_hit_in;
   logic [LCNT_W-1:0]   o_idx_ff, o_idx_in;
   level_type           o_lvl_ff, o_lvl_in;
   logic [LCNT_W-1:0]   k_ff, k_in;
   logic [LCNT_W-1:0]   bid_used_ff, bid_used_in;
   logic [LCNT_W-1:0]   ask_used_ff, ask_used_in;
   logic                dropped_ff, dropped_in;
   logic [OIDX_W-1:0]   cl_ff, cl_in;
   logic                clr_emit_ff, clr_emit_in;
   logic [RANK_W-1:0]   er_ff, er_in;
   logic                es_ff, es_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_side_ff, rsp_side_in;
   logic [3:0]          rsp_rank_ff, rsp_rank_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [PRICE_W-1:0]  rsp_price_ff, rsp_price_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                rsp_overflow_ff, rsp_overflow_in;
   logic                rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                s_we, s_re;
   logic [OIDX_W-1:0]   s_waddr, s_raddr;
   slot_type            s_wdata, s_rdata;
   logic                l_we, l_re;
   logic [LADR_W-1:0]   l_waddr, l_raddr;
   level_type           l_wdata, l_rdata;

   logic [LCNT_W-1:0]        used_sel;
   logic [LCNT_W-1:0]        emit_used;
   logic                     req_fire;
   logic                     add_ok;
   logic                     mod_price_ok;
   logic [TOTAL_W:0]         sum_tot;
   logic [TOTAL_W-1:0]       sat_tot;
   logic [TOTAL_W-1:0]       rem_tot;
   logic [CNT_W-1:0]         rem_cnt;
   logic [LIDX_W+RANK_W-1:0] er_wide;
   logic [RANK_W+3:0]        er_rank;
   logic                     er_present;

   obl_ram #(.WIDTH($bits(slot_type)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   // Both sides share one level memory: the top address bit is the side.
   obl_ram #(.WIDTH($bits(level_type)), .DEPTH(2 * LEVEL_SLOTS)) u_level_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_en   (l_re),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // A new order needs a price strictly between zero and the largest value.
   assign mod_price_ok = !req_price[63] && (req_price != '0)
                         && (req_price != PRICE_MAX);
   assign add_ok = mod_price_ok && (req_quantity != '0) && !req_side[1];

   assign used_sel  = side_ff ? ask_used_ff : bid_used_ff;
   assign emit_used = es_ff ? ask_used_ff : bid_used_ff;

   assign sum_tot = {1'b0, f_lvl_ff.total} + (TOTAL_W + 1)'(qty_ff);
   assign sat_tot = sum_tot[TOTAL_W] ? TOTAL_MAX : sum_tot[TOTAL_W-1:0];
   assign rem_tot = (o_lvl_ff.total >= TOTAL_W'(m_slot_ff.size))
                    ? o_lvl_ff.total - TOTAL_W'(m_slot_ff.size) : '0;
   assign rem_cnt = (o_lvl_ff.count == '0) ? '0 : o_lvl_ff.count - CNT_W'(1);

   assign er_wide    = {{LIDX_W{1'b0}}, er_ff};
   assign er_rank    = {4'b0000, er_ff};
   assign er_present = ({{LCNT_W{1'b0}}, er_ff} < {{RANK_W{1'b0}}, emit_used});

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      id_in           = id_ff;
      side_in         = side_ff;
      price_in        = price_ff;
      qty_in          = qty_ff;
      phase_in        = phase_ff;
      sa_in           = sa_ff;
      srv_in          = 1'b0;
      sraddr_in       = sa_ff[OIDX_W-1:0];
      m_hit_in        = m_hit_ff;
      m_idx_in        = m_idx_ff;
      m_slot_in       = m_slot_ff;
      fr_hit_in       = fr_hit_ff;
      fr_idx_in       = fr_idx_ff;
      fp_in           = fp_ff;
      fi_in           = fi_ff;
      f_hit_in        = f_hit_ff;
      f_idx_in        = f_idx_ff;
      f_lvl_in        = f_lvl_ff;
      o_hit_in        = o_hit_ff;
      o_idx_in        = o_idx_ff;
      o_lvl_in        = o_lvl_ff;
      k_in            = k_ff;
      bid_used_in     = bid_used_ff;
      ask_used_in     = ask_used_ff;
      dropped_in      = dropped_ff;
      cl_in           = cl_ff;
      clr_emit_in     = clr_emit_ff;
      er_in           = er_ff;
      es_in           = es_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_side_in     = rsp_side_ff;
      rsp_rank_in     = rsp_rank_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_price_in    = rsp_price_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_last_in     = rsp_last_ff;

      s_we    = 1'b0;
      s_waddr = m_idx_ff;
      s_wdata = '0;
      s_re    = 1'b0;
      s_raddr = sa_ff[OIDX_W-1:0];
      l_we    = 1'b0;
      l_waddr = lvl_addr(side_ff, f_idx_ff);
      l_wdata = l_rdata;
      l_re    = 1'b0;
      l_raddr = lvl_addr(side_ff, fi_ff);

      unique case (state_ff)
         S_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = cl_ff;
            s_wdata = '0;
            if (cl_ff == OIDX_W'(ORDER_SLOTS - 1)) begin
               cl_in = '0;
               if (clr_emit_ff) begin
                  es_in    = 1'b1;
                  er_in    = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cl_in = cl_ff + OIDX_W'(1);
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_action;
               id_in     = req_order_id;
               side_in   = req_side[0];
               price_in  = req_price;
               qty_in    = req_quantity;
               sa_in     = '0;
               m_hit_in  = 1'b0;
               fr_hit_in = 1'b0;
               es_in     = 1'b1;
               er_in     = '0;
               case (req_action)
                  ACT_ADD:    state_in = add_ok ? S_SCAN : S_EMIT_RD;
                  ACT_CANCEL: state_in = S_SCAN;
                  ACT_MODIFY: state_in = mod_price_ok ? S_SCAN : S_EMIT_RD;
                  ACT_CLEAR: begin
                     bid_used_in = '0;
                     ask_used_in = '0;
                     dropped_in  = 1'b0;
                     cl_in       = '0;
                     clr_emit_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default:    state_in = S_EMIT_RD;
               endcase
            end
         end

         // One slot read issued and one checked each cycle.
         S_SCAN: begin
            if (sa_ff < OCNT_W'(ORDER_SLOTS)) begin
               s_re   = 1'b1;
               srv_in = 1'b1;
               sa_in  = sa_ff + OCNT_W'(1);
            end
            if (srv_ff) begin
               if (s_rdata.valid && (s_rdata.id == id_ff)) begin
                  m_hit_in  = 1'b1;
                  m_idx_in  = sraddr_ff;
                  m_slot_in = s_rdata;
                  srv_in    = 1'b0;
                  state_in  = S_SCAN_END;
               end else if (!s_rdata.valid && !fr_hit_ff) begin
                  fr_hit_in = 1'b1;
                  fr_idx_in = sraddr_ff;
               end
            end else if (sa_ff == OCNT_W'(ORDER_SLOTS)) begin
               state_in = S_SCAN_END;
            end
         end

         S_SCAN_END: begin
            fi_in = '0;
            if (act_ff == ACT_ADD) begin
               if (m_hit_ff || !fr_hit_ff) begin
                  dropped_in = 1'b1;
                  state_in   = S_EMIT_RD;
               end else begin
                  fp_in    = price_ff;
                  phase_in = PH_ADDNEW;
                  state_in = S_FIND_RD;
               end
            end else if (m_hit_ff) begin
               side_in  = m_slot_ff.ask;
               fp_in    = m_slot_ff.price;
               phase_in = PH_OLD;
               state_in = S_FIND_RD;
            end else begin
               state_in = S_EMIT_RD;
            end
         end

         S_FIND_RD: begin
            if (fi_ff == used_sel) begin
               f_hit_in = 1'b0;
               f_idx_in = fi_ff;
               state_in = S_DECIDE;
            end else begin
               l_re     = 1'b1;
               l_raddr  = lvl_addr(side_ff, fi_ff);
               state_in = S_FIND_CHK;
            end
         end

         S_FIND_CHK: begin
            if (l_rdata.price == fp_ff) begin
               f_hit_in = 1'b1;
               f_idx_in = fi_ff;
               f_lvl_in = l_rdata;
               state_in = S_DECIDE;
            end else if (side_ff ? (fp_ff < l_rdata.price) : (fp_ff > l_rdata.price)) begin
               f_hit_in = 1'b0;
               f_idx_in = fi_ff;
               state_in = S_DECIDE;
            end else begin
               fi_in    = fi_ff + LCNT_W'(1);
               state_in = S_FIND_RD;
            end
         end

         S_DECIDE: begin
            case (phase_ff)
               PH_ADDNEW: begin
                  if (!f_hit_ff && (used_sel == LCNT_W'(LEVEL_SLOTS))) begin
                     dropped_in = 1'b1;
                     state_in   = S_EMIT_RD;
                  end else begin
                     s_we          = 1'b1;
                     s_waddr       = fr_idx_ff;
                     s_wdata.id    = id_ff;
                     s_wdata.price = price_ff;
                     s_wdata.size  = qty_ff;
                     s_wdata.ask   = side_ff;
                     s_wdata.valid = 1'b1;
                     state_in      = S_LADD;
                  end
               end
               PH_OLD: begin
                  o_hit_in = f_hit_ff;
                  o_idx_in = f_idx_ff;
                  o_lvl_in = f_lvl_ff;
                  if ((act_ff == ACT_MODIFY) && (m_slot_ff.price != price_ff)) begin
                     fp_in    = price_ff;
                     fi_in    = '0;
                     phase_in = PH_CHK;
                     state_in = S_FIND_RD;
                  end else begin
                     state_in = S_LREM;
                  end
               end
               PH_CHK: begin
                  // A move is refused only if the new level is missing, the
                  // side is full, and the old level does not empty.
                  if (!(f_hit_ff || (used_sel < LCNT_W'(LEVEL_SLOTS)))
                      && !(o_hit_ff && (o_lvl_ff.count == CNT_W'(1)))) begin
                     dropped_in = 1'b1;
                     state_in   = S_EMIT_RD;
                  end else begin
                     state_in = S_LREM;
                  end
               end
               default: state_in = S_LADD;
            endcase
         end

         S_LADD: begin
            if (f_hit_ff) begin
               l_we          = 1'b1;
               l_waddr       = lvl_addr(side_ff, f_idx_ff);
               l_wdata.price = f_lvl_ff.price;
               l_wdata.total = sat_tot;
               l_wdata.count = f_lvl_ff.count + CNT_W'(1);
               state_in      = S_ADD_END;
            end else if (used_sel == LCNT_W'(LEVEL_SLOTS)) begin
               state_in = S_ADD_END;
            end else begin
               k_in     = used_sel - f_idx_ff;
               state_in = S_SHUP_RD;
            end
         end

         // Shift the levels below the insertion point down by one.
         S_SHUP_RD: begin
            if (k_ff == '0) begin
               l_we          = 1'b1;
               l_waddr       = lvl_addr(side_ff, f_idx_ff);
               l_wdata.price = price_ff;
               l_wdata.total = TOTAL_W'(qty_ff);
               l_wdata.count = CNT_W'(1);
               if (side_ff) begin
                  ask_used_in = ask_used_ff + LCNT_W'(1);
               end else begin
                  bid_used_in = bid_used_ff + LCNT_W'(1);
               end
               state_in = S_ADD_END;
            end else begin
               l_re     = 1'b1;
               l_raddr  = lvl_addr(side_ff, f_idx_ff + k_ff - LCNT_W'(1));
               state_in = S_SHUP_WR;
            end
         end

         S_SHUP_WR: begin
            l_we     = 1'b1;
            l_waddr  = lvl_addr(side_ff, f_idx_ff + k_ff);
            l_wdata  = l_rdata;
            k_in     = k_ff - LCNT_W'(1);
            state_in = S_SHUP_RD;
         end

         S_LREM: begin
            if (!o_hit_ff) begin
               state_in = S_REM_END;
            end else if (rem_cnt != '0) begin
               l_we          = 1'b1;
               l_waddr       = lvl_addr(side_ff, o_idx_ff);
               l_wdata.price = o_lvl_ff.price;
               l_wdata.total = rem_tot;
               l_wdata.count = rem_cnt;
               state_in      = S_REM_END;
            end else begin
               k_in     = o_idx_ff;
               state_in = S_SHDN_RD;
            end
         end

         // Close the gap left by an emptied level.
         S_SHDN_RD: begin
            if ((k_ff + LCNT_W'(1)) >= used_sel) begin
               if (side_ff) begin
                  ask_used_in = ask_used_ff - LCNT_W'(1);
               end else begin
                  bid_used_in = bid_used_ff - LCNT_W'(1);
               end
               state_in = S_REM_END;
            end else begin
               l_re     = 1'b1;
               l_raddr  = lvl_addr(side_ff, k_ff + LCNT_W'(1));
               state_in = S_SHDN_WR;
            end
         end

         S_SHDN_WR: begin
            l_we     = 1'b1;
            l_waddr  = lvl_addr(side_ff, k_ff);
            l_wdata  = l_rdata;
            k_in     = k_ff + LCNT_W'(1);
            state_in = S_SHDN_RD;
         end

         S_ADD_END: begin
            if (act_ff == ACT_MODIFY) begin
               s_we          = 1'b1;
               s_waddr       = m_idx_ff;
               s_wdata.id    = id_ff;
               s_wdata.price = price_ff;
               s_wdata.size  = qty_ff;
               s_wdata.ask   = m_slot_ff.ask;
               s_wdata.valid = 1'b1;
            end
            state_in = S_EMIT_RD;
         end

         S_REM_END: begin
            if (act_ff == ACT_MODIFY) begin
               fp_in    = price_ff;
               fi_in    = '0;
               phase_in = PH_ADD;
               state_in = S_FIND_RD;
            end else begin
               s_we     = 1'b1;
               s_waddr  = m_idx_ff;
               s_wdata  = '0;
               state_in = S_EMIT_RD;
            end
         end

         S_EMIT_RD: begin
            l_re     = 1'b1;
            l_raddr  = {es_ff, er_wide[LIDX_W-1:0]};
            state_in = S_EMIT_CAP;
         end

         S_EMIT_CAP: begin
            rsp_valid_in    = 1'b1;
            rsp_side_in     = es_ff;
            rsp_rank_in     = er_rank[3:0];
            rsp_present_in  = er_present;
            rsp_price_in    = er_present ? l_rdata.price : '0;
            rsp_total_in    = er_present ? l_rdata.total : '0;
            rsp_overflow_in = dropped_ff;
            rsp_last_in     = !es_ff && (er_ff == RANK_W'(TOP_LEVELS - 1));
            state_in        = S_EMIT_WAIT;
         end

         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (er_ff == RANK_W'(TOP_LEVELS - 1)) begin
                  er_in = '0;
                  if (es_ff) begin
                     es_in    = 1'b0;
                     state_in = S_EMIT_RD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  er_in    = er_ff + RANK_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cl_ff        <= '0;
         clr_emit_ff  <= 1'b0;
         bid_used_ff  <= '0;
         ask_used_ff  <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         srv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cl_ff        <= cl_in;
         clr_emit_ff  <= clr_emit_in;
         bid_used_ff  <= bid_used_in;
         ask_used_ff  <= ask_used_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         srv_ff       <= srv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      id_ff           <= id_in;
      side_ff         <= side_in;
      price_ff        <= price_in;
      qty_ff          <= qty_in;
      phase_ff        <= phase_in;
      sa_ff           <= sa_in;
      sraddr_ff       <= sraddr_in;
      m_hit_ff        <= m_hit_in;
      m_idx_ff        <= m_idx_in;
      m_slot_ff       <= m_slot_in;
      fr_hit_ff       <= fr_hit_in;
      fr_idx_ff       <= fr_idx_in;
      fp_ff           <= fp_in;
      fi_ff           <= fi_in;
      f_hit_ff        <= f_hit_in;
      f_idx_ff        <= f_idx_in;
      f_lvl_ff        <= f_lvl_in;
      o_hit_ff        <= o_hit_in;
      o_idx_ff        <= o_idx_in;
      o_lvl_ff        <= o_lvl_in;
      k_ff            <= k_in;
      er_ff           <= er_in;
      es_ff           <= es_in;
      rsp_side_ff     <= rsp_side_in;
      rsp_rank_ff     <= rsp_rank_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_price_ff    <= rsp_price_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_side  = rsp_side_ff;
   assign rsp_level_rank  = rsp_rank_ff;
   assign rsp_present     = rsp_present_ff;
   assign rsp_level_price = rsp_price_ff;
   assign rsp_level_total = rsp_total_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== bench/tb_order_book_level_builder_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the market-by-order level builder.
// Every accepted event item goes through a behavioural book kept in this
// module, which queues the twenty level items that the block should send
// back. A monitor compares each returned item with the oldest queued one.
module tb_order_book_level_builder_top;
   import obl_pkg::*;

   // Action and side codes that the package does not name.
   localparam logic [2:0] ACT_NONE  = 3'd4;
   localparam logic [2:0] ACT_SPARE = 3'd7;
   localparam logic [1:0] SIDE_NONE = 2'd2;
   localparam logic [1:0] SIDE_BAD  = 2'd3;

   // The order search may walk the whole order table for each event, level
   // work adds shifts through the level table, and twenty items may each wait
   // out a long receiver stall. The limit is meant to lie above the slowest run.
   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int     DRAIN_CYCLES = 2 * ORDER_SLOTS + 4000;
   localparam int     MAX_PRINTS = 40;

   typedef struct {
      logic              side;
      logic [3:0]        rank;
      logic              present;
      logic [63:0]       price;
      logic [47:0]       total;
      logic              overflow;
      logic              last;
   } level_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [63:0] req_order_id = '0;
   logic [1:0] req_side = '0;
   logic signed [63:0] req_price = '0;
   logic [31:0] req_quantity = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_level_side;
   logic [3:0] rsp_level_rank;
   logic rsp_present;
   logic signed [63:0] rsp_level_price;
   logic [47:0] rsp_level_total;
   logic rsp_overflow;
   logic rsp_last;

   order_book_level_builder_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_order_id(req_order_id), .req_side(req_side),
      .req_price(req_price), .req_quantity(req_quantity),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_level_side(rsp_level_side), .rsp_level_rank(rsp_level_rank),
      .rsp_present(rsp_present), .rsp_level_price(rsp_level_price),
      .rsp_level_total(rsp_level_total), .rsp_overflow(rsp_overflow),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Behavioural book. Index 1 of the level tables is the ask side.
   // ---------------------------------------------------------------------
   logic [63:0] ord_id    [ORDER_SLOTS];
   logic [63:0] ord_price [ORDER_SLOTS];
   logic [31:0] ord_size  [ORDER_SLOTS];
   logic        ord_ask   [ORDER_SLOTS];
   logic        ord_live  [ORDER_SLOTS];
   logic [63:0] lvl_price [2][LEVEL_SLOTS];
   logic [63:0] lvl_total [2][LEVEL_SLOTS];
   int          lvl_count [2][LEVEL_SLOTS];
   int          lvl_used  [2];
   logic        book_dropped;

   level_item_type level_expect_q[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int events_sent = 0;
   int items_checked = 0;
   int mismatches = 0;
   longint cycle_count = 0;
   level_item_type got_item;
   level_item_type want_item;

   // Stored prices are always 1 .. PRICE_MAX-1, so unsigned compares hold.
   function automatic bit price_valid(logic [63:0] p);
      return p != 64'd0 && p < PRICE_MAX;
   endfunction

   function automatic int find_level(int ask, logic [63:0] p, output bit hit);
      int i;
      hit = 1'b0;
      for (i = 0; i < lvl_used[ask]; i++) begin
         if (lvl_price[ask][i] == p) begin
            hit = 1'b1;
            return i;
         end
         if (ask ? (p < lvl_price[ask][i]) : (p > lvl_price[ask][i])) break;
      end
      return i;
   endfunction

   function automatic bit level_has_room(int ask, logic [63:0] p);
      bit hit;
      int i;
      i = find_level(ask, p, hit);
      return hit || lvl_used[ask] < LEVEL_SLOTS;
   endfunction

   function automatic void level_insert(int ask, logic [63:0] p, logic [31:0] q);
      bit hit;
      int i;
      logic [63:0] sum;
      i = find_level(ask, p, hit);
      if (!hit) begin
         if (lvl_used[ask] >= LEVEL_SLOTS) return;
         for (int j = lvl_used[ask]; j > i; j--) begin
            lvl_price[ask][j] = lvl_price[ask][j-1];
            lvl_total[ask][j] = lvl_total[ask][j-1];
            lvl_count[ask][j] = lvl_count[ask][j-1];
         end
         lvl_price[ask][i] = p;
         lvl_total[ask][i] = 64'd0;
         lvl_count[ask][i] = 0;
         lvl_used[ask]++;
      end
      sum = lvl_total[ask][i] + 64'(q);
      lvl_total[ask][i] = (sum > {16'd0, TOTAL_MAX}) ? {16'd0, TOTAL_MAX} : sum;
      lvl_count[ask][i]++;
   endfunction

   function automatic void level_withdraw(int ask, logic [63:0] p, logic [31:0] q);
      bit hit;
      int i;
      i = find_level(ask, p, hit);
      if (!hit) return;
      lvl_total[ask][i] = (lvl_total[ask][i] >= 64'(q)) ? lvl_total[ask][i] - 64'(q)
                                                       : 64'd0;
      if (lvl_count[ask][i] > 0) lvl_count[ask][i]--;
      if (lvl_count[ask][i] == 0) begin
         for (int j = i; j < lvl_used[ask] - 1; j++) begin
            lvl_price[ask][j] = lvl_price[ask][j+1];
            lvl_total[ask][j] = lvl_total[ask][j+1];
            lvl_count[ask][j] = lvl_count[ask][j+1];
         end
         lvl_used[ask]--;
      end
   endfunction

   function automatic int find_order(logic [63:0] id);
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (ord_live[i] && ord_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void book_add(logic [63:0] id, logic [1:0] side, logic [63:0] p,
                                    logic [31:0] q);
      int free_slot;
      int ask;
      free_slot = -1;
      ask = int'(side[0]);
      if (!price_valid(p) || q == 32'd0 || side > SIDE_ASK) return;
      if (find_order(id) >= 0) begin
         book_dropped = 1'b1;
         return;
      end
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (!ord_live[i]) begin
            free_slot = i;
            break;
         end
      if (free_slot < 0 || !level_has_room(ask, p)) begin
         book_dropped = 1'b1;
         return;
      end
      ord_id[free_slot] = id;
      ord_price[free_slot] = p;
      ord_size[free_slot] = q;
      ord_ask[free_slot] = 1'(ask);
      ord_live[free_slot] = 1'b1;
      level_insert(ask, p, q);
   endfunction

   function automatic void book_modify(logic [63:0] id, logic [63:0] p, logic [31:0] q);
      int s;
      int ask;
      int i;
      bit hit;
      bit frees;
      s = find_order(id);
      if (s < 0 || !price_valid(p)) return;
      ask = int'(ord_ask[s]);
      if (ord_price[s] != p) begin
         // Moving out of a single-order level frees the room it needs.
         i = find_level(ask, ord_price[s], hit);
         frees = hit && lvl_count[ask][i] == 1;
         if (!level_has_room(ask, p) && !frees) begin
            book_dropped = 1'b1;
            return;
         end
      end
      level_withdraw(ask, ord_price[s], ord_size[s]);
      level_insert(ask, p, q);
      ord_price[s] = p;
      ord_size[s] = q;
   endfunction

   function automatic void book_clear();
      for (int i = 0; i < ORDER_SLOTS; i++) ord_live[i] = 1'b0;
      lvl_used[0] = 0;
      lvl_used[1] = 0;
      book_dropped = 1'b0;
   endfunction

   // Applies one event and queues the ask ranks, then the bid ranks.
   function automatic void apply_event(logic [2:0] action, logic [63:0] id,
                                       logic [1:0] side, logic [63:0] p, logic [31:0] q);
      int s;
      level_item_type it;
      case (action)
         ACT_ADD: begin
            book_add(id, side, p, q);
         end
         ACT_CANCEL: begin
            s = find_order(id);
            if (s >= 0) begin
               level_withdraw(int'(ord_ask[s]), ord_price[s], ord_size[s]);
               ord_live[s] = 1'b0;
            end
         end
         ACT_MODIFY: begin
            book_modify(id, p, q);
         end
         ACT_CLEAR: begin
            book_clear();
         end
         default: begin
         end
      endcase
      for (int pass = 0; pass < 2; pass++) begin
         int ask;
         ask = (pass == 0) ? 1 : 0;
         for (int r = 0; r < TOP_LEVELS; r++) begin
            it.side = 1'(ask);
            it.rank = 4'(r);
            it.present = r < lvl_used[ask];
            it.price = it.present ? lvl_price[ask][r] : 64'd0;
            it.total = it.present ? lvl_total[ask][r][47:0] : 48'd0;
            it.overflow = book_dropped;
            it.last = (pass == 1 && r == TOP_LEVELS - 1);
            level_expect_q = {level_expect_q, it};
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driving, receiving and checking.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("MISMATCH item %0d %s: got %h expected %h", items_checked, what, got, want);
   endtask

   // Offers one event item, holds it until accepted, then maybe idles.
   task automatic send_event(logic [2:0] action, logic [63:0] id, logic [1:0] side,
                             logic [63:0] p, logic [31:0] q);
      req_action <= action;
      req_order_id <= id;
      req_side <= side;
      req_price <= p;
      req_quantity <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_event(action, id, side, p, q);
      events_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding.",
                  cycle_count, level_expect_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Each returned item is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_item.side = rsp_level_side;
         got_item.rank = rsp_level_rank;
         got_item.present = rsp_present;
         got_item.price = rsp_level_price;
         got_item.total = rsp_level_total;
         got_item.overflow = rsp_overflow;
         got_item.last = rsp_last;
         if (level_expect_q.size() == 0) begin
            report_mismatch("unexpected item", 64'(got_item.last), 64'd0);
         end else begin
            want_item = level_expect_q.pop_front();
            if (got_item.side !== want_item.side)
               report_mismatch("level_side", 64'(got_item.side), 64'(want_item.side));
            if (got_item.rank !== want_item.rank)
               report_mismatch("level_rank", 64'(got_item.rank), 64'(want_item.rank));
            if (got_item.present !== want_item.present)
               report_mismatch("present", 64'(got_item.present), 64'(want_item.present));
            if (got_item.price !== want_item.price)
               report_mismatch("level_price", got_item.price, want_item.price);
            if (got_item.total !== want_item.total)
               report_mismatch("level_total", 64'(got_item.total), 64'(want_item.total));
            if (got_item.overflow !== want_item.overflow)
               report_mismatch("overflow", 64'(got_item.overflow), 64'(want_item.overflow));
            if (got_item.last !== want_item.last)
               report_mismatch("last", 64'(got_item.last), 64'(want_item.last));
         end
         items_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Field extremes on adds, a duplicate ID and every kind of field that rejects an add.
   task automatic test_adds_and_rejects();
      send_event(ACT_ADD, 64'd0, SIDE_BID, 64'd1, 32'hFFFF_FFFF);
      send_event(ACT_ADD, '1, SIDE_ASK, PRICE_MAX - 1, 32'd1);
      send_event(ACT_ADD, 64'd0, SIDE_ASK, 64'd50, 32'd7);
      send_event(ACT_ADD, 64'd9, SIDE_BID, 64'd0, 32'd5);
      send_event(ACT_ADD, 64'd9, SIDE_BID, 64'h8000_0000_0000_0000, 32'd5);
      send_event(ACT_ADD, 64'd9, SIDE_BID, '1, 32'd5);
      send_event(ACT_ADD, 64'd9, SIDE_ASK, PRICE_MAX, 32'd5);
      send_event(ACT_ADD, 64'd9, SIDE_ASK, 64'd20, 32'd0);
      send_event(ACT_ADD, 64'd9, SIDE_NONE, 64'd20, 32'd5);
      send_event(ACT_ADD, 64'd9, SIDE_BAD, 64'd20, 32'd5);
   endtask

   // Unknown IDs, bad modify prices, a size of zero and a level move.
   task automatic test_cancel_and_modify();
      send_event(ACT_CANCEL, 64'd77, SIDE_BID, 64'd0, 32'd0);
      send_event(ACT_MODIFY, 64'd77, SIDE_BID, 64'd3, 32'd3);
      send_event(ACT_MODIFY, 64'd0, SIDE_BID, 64'd0, 32'd3);
      send_event(ACT_MODIFY, 64'd0, SIDE_BID, PRICE_MAX, 32'd3);
      send_event(ACT_MODIFY, 64'd0, SIDE_BID, 64'd1, 32'd0);
      send_event(ACT_MODIFY, 64'd0, SIDE_ASK, 64'd2, 32'd40);
      send_event(ACT_ADD, 64'd5, SIDE_BID, 64'd2, 32'd8);
      send_event(ACT_CANCEL, 64'd5, SIDE_BID, 64'd2, 32'd8);
      send_event(ACT_CANCEL, '1, SIDE_BID, 64'd0, 32'd0);
   endtask

   // No-op actions keep the book; clear empties it and drops the flag.
   task automatic test_noop_and_clear();
      send_event(ACT_NONE, 64'd0, SIDE_BID, 64'd3, 32'd3);
      send_event(ACT_SPARE, '1, SIDE_BAD, '1, '1);
      send_event(ACT_CLEAR, 64'd0, SIDE_BID, 64'd0, 32'd0);
      send_event(ACT_ADD, 64'd0, SIDE_ASK, 64'd11, 32'd2);
      send_event(ACT_CLEAR, 64'd0, SIDE_BID, 64'd0, 32'd0);
   endtask

   // Fills the bid level table, then tries a new level by add and by modify
   // (dropped) and a modify out of a single-order level (allowed).
   task automatic test_level_table_full();
      for (int i = 0; i < LEVEL_SLOTS; i++)
         send_event(ACT_ADD, 64'd1000 + 64'(i), SIDE_BID, 64'd100 + 64'(i), 32'd1 + i);
      send_event(ACT_ADD, 64'd5000, SIDE_BID, 64'd9999, 32'd1);
      send_event(ACT_ADD, 64'd5001, SIDE_BID, 64'd105, 32'd3);
      send_event(ACT_MODIFY, 64'd5001, SIDE_BID, 64'd9999, 32'd3);
      send_event(ACT_MODIFY, 64'd1000, SIDE_BID, 64'd9999, 32'd4);
      send_event(ACT_ADD, 64'd5002, SIDE_ASK, 64'd9999, 32'd6);
      send_event(ACT_CLEAR, 64'd0, SIDE_BID, 64'd0, 32'd0);
   endtask

   logic [63:0] id_pool[$];

   function automatic logic [63:0] pick_id();
      if ($urandom_range(99) < 88) return id_pool[$urandom_range(id_pool.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_price();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return 64'd1000 + 64'($urandom_range(30));
      if (roll < 85) return 64'd1 + 64'($urandom_range(3));
      if (roll < 93) return {$urandom, $urandom};
      case ($urandom_range(3))
         0: return 64'd0;
         1: return PRICE_MAX;
         2: return PRICE_MAX - 1;
         default: return '1;
      endcase
   endfunction

   function automatic logic [31:0] pick_quantity();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return 32'd1 + $urandom_range(500);
      if (roll < 94) return $urandom;
      return (roll < 97) ? 32'd0 : 32'hFFFF_FFFF;
   endfunction

   // Mostly well-formed traffic on a small ID pool so that orders live long
   // enough to be cancelled and moved; the rest is rejects and noise.
   task automatic test_random_traffic(int count);
      int roll;
      logic [2:0] action;
      logic [1:0] side;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 45) action = ACT_ADD;
         else if (roll < 68) action = ACT_CANCEL;
         else if (roll < 92) action = ACT_MODIFY;
         else if (roll < 94) action = ACT_CLEAR;
         else action = ACT_NONE + 3'($urandom_range(3));
         side = ($urandom_range(99) < 92) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
         send_event(action, pick_id(), side, pick_price(), pick_quantity());
      end
   endtask

   initial begin
      for (int i = 0; i < ORDER_SLOTS; i++) ord_live[i] = 1'b0;
      book_clear();
      id_pool = {id_pool, 64'd0};
      id_pool = {id_pool, 64'hFFFF_FFFF_FFFF_FFFF};
      id_pool = {id_pool, 64'h8000_0000_0000_0000};
      for (int i = 0; i < 21; i++) id_pool = {id_pool, {$urandom, $urandom}};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_adds_and_rejects();
      test_cancel_and_modify();
      test_noop_and_clear();

      // Random traffic in four idling phases, the first with none at all.
      idle_pct = 0;
      stall_pct = 0;
      test_random_traffic(46);
      test_level_table_full();
      idle_pct = 88;
      test_random_traffic(46);
      idle_pct = 0;
      stall_pct = 88;
      test_random_traffic(46);
      idle_pct = 34;
      stall_pct = 34;
      test_random_traffic(46);

      @(posedge clock);
      req_valid <= 1'b0;
      while (level_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (level_expect_q.size() != 0)
         report_mismatch("items never returned", 64'(level_expect_q.size()), 64'd0);

      $display("Run covered %0d event items and %0d level items in %0d cycles.",
               events_sent, items_checked, cycle_count);
      $display("Phases: directed rejects, full bid level table, four idling mixes.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
